/* rtl/mmp_pkg.sv */
// shared constants, handler codes, types and the handler fallback function
// for the midi message parser; no dependencies
package mmp_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned MaxDepth     = 64;
  localparam int unsigned MaxLenW      = $clog2(MaxDepth + 1);
  localparam int unsigned MsgLenW      = 6;
  localparam int unsigned CapW         = 6;
  localparam int unsigned EnW          = 7;
  localparam int unsigned CfgDataW     = 7;

  localparam logic [7:0] StatusMask = 8'h80;
  localparam logic [7:0] SysexStart = 8'hF0;
  localparam logic [7:0] SysexEnd   = 8'hF7;

  // configuration register indexes
  localparam logic RegEnable   = 1'b0;
  localparam logic RegCapacity = 1'b1;

  // handler codes
  localparam logic [2:0] HVoice   = 3'd0;
  localparam logic [2:0] HCc      = 3'd1;
  localparam logic [2:0] HRt      = 3'd2;
  localparam logic [2:0] HCommon  = 3'd3;
  localparam logic [2:0] HSysex   = 3'd4;
  localparam logic [2:0] HMtc     = 3'd5;
  localparam logic [2:0] HDefault = 3'd6;
  localparam logic [2:0] HNone    = 3'd7;

  // request from the parser to the emitter to send out a finished message
  typedef struct packed {
    logic               valid;
    logic [MaxLenW-1:0] len;
    logic [2:0]         hdl;
  } start_t;

  // first enabled of a, b, then default; HNone when nothing is enabled
  function automatic logic [2:0] pick_handler(logic [EnW-1:0] en, logic [2:0] a,
                                              logic [2:0] b);
    logic [7:0] en8;
    logic [2:0] h;
    en8 = {1'b0, en};
    h   = HNone;
    if (a != HNone && en8[a]) begin
      h = a;
    end else if (b != HNone && en8[b]) begin
      h = b;
    end else if (en8[HDefault]) begin
      h = HDefault;
    end
    return h;
  endfunction

endpackage

/* rtl/mmp_store.sv */
// message store: single write port, one registered read port
// depends on nothing but its parameter
module mmp_store #(
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/mmp_ctrl.sv */
// parser control: mode, fill count, status byte copy, configuration and
// message classification; uses mmp_pkg, writes the message store
module mmp_ctrl #(
  parameter int unsigned Depth = mmp_pkg::DefaultDepth,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mmp_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          we_o,
  output logic [AddrW-1:0]              waddr_o,
  output mmp_pkg::start_t               start_o
);

  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeMsg   = 2'd1;
  localparam logic [1:0] ModeSysex = 2'd2;

  logic [1:0]              mode_q, mode_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic [7:0]              s0_q, s0_d;
  logic [mmp_pkg::EnW-1:0] en_q;
  logic [mmp_pkg::CapW-1:0] cap_q;

  logic [CntW-1:0] cap_use, cap_new;
  logic [1:0]      mode_a;
  logic [CntW-1:0] fill_a, fill_b;
  logic            we;
  logic            done;
  logic [2:0]      chain_a, chain_b, hdl;
  logic [3:0]      hi;

  always_comb begin
    if (32'(cap_q) < Depth) cap_use = CntW'(cap_q);
    else                    cap_use = CntW'(Depth);
    if (32'(cfg_data_i[mmp_pkg::CapW-1:0]) < Depth) begin
      cap_new = CntW'(cfg_data_i[mmp_pkg::CapW-1:0]);
    end else begin
      cap_new = CntW'(Depth);
    end
  end

  always_comb begin
    mode_a  = mode_q;
    fill_a  = fill_q;
    mode_d  = mode_q;
    fill_d  = fill_q;
    s0_d    = s0_q;
    we      = 1'b0;
    fill_b  = fill_q;
    done    = 1'b0;
    chain_a = mmp_pkg::HNone;
    chain_b = mmp_pkg::HNone;

    // status byte handling
    if ((data_byte_i & mmp_pkg::StatusMask) != 8'h00) begin
      if (mode_q == ModeSysex) begin
        if (data_byte_i != mmp_pkg::SysexEnd) begin
          mode_a = ModeIdle;
          fill_a = '0;
        end
      end else if (data_byte_i == mmp_pkg::SysexStart) begin
        mode_a = ModeSysex;
        fill_a = '0;
      end else begin
        mode_a = ModeMsg;
        fill_a = '0;
      end
    end

    // append, or drop on overflow
    mode_d = mode_a;
    fill_b = fill_a;
    if (mode_a != ModeIdle) begin
      if (fill_a < cap_use) begin
        we     = 1'b1;
        fill_b = fill_a + CntW'(1);
      end else begin
        mode_d = ModeIdle;
        fill_b = '0;
      end
    end
    fill_d = fill_b;

    // entry zero is mirrored so the status byte is at hand
    if (we && fill_a == '0) s0_d = data_byte_i;
    hi = s0_d[7:4];

    if (mode_d == ModeMsg) begin
      case (fill_b)
        CntW'(1): begin
          if (s0_d inside {8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF}) begin
            done = 1'b1; chain_a = mmp_pkg::HRt;
          end else if (s0_d == 8'hF6) begin
            done = 1'b1; chain_a = mmp_pkg::HCommon;
          end
        end
        CntW'(2): begin
          if (hi inside {4'hC, 4'hD}) begin
            done = 1'b1; chain_a = mmp_pkg::HVoice;
          end else if (s0_d == 8'hF1) begin
            done = 1'b1; chain_a = mmp_pkg::HMtc; chain_b = mmp_pkg::HCommon;
          end else if (s0_d == 8'hF3) begin
            done = 1'b1; chain_a = mmp_pkg::HCommon;
          end
        end
        CntW'(3): begin
          if (hi == 4'hB) begin
            done = 1'b1; chain_a = mmp_pkg::HCc; chain_b = mmp_pkg::HVoice;
          end else if (hi inside {4'h8, 4'h9, 4'hA, 4'hE}) begin
            done = 1'b1; chain_a = mmp_pkg::HVoice;
          end else if (s0_d == 8'hF2) begin
            done = 1'b1; chain_a = mmp_pkg::HCommon;
          end
        end
        default: ;
      endcase
    end else if (mode_d == ModeSysex && we && data_byte_i == mmp_pkg::SysexEnd) begin
      done = 1'b1; chain_a = mmp_pkg::HSysex;
    end

    hdl = mmp_pkg::pick_handler(en_q, chain_a, chain_b);
    if (done) begin
      mode_d = ModeIdle;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      fill_q <= '0;
      en_q   <= '0;
      cap_q  <= mmp_pkg::CapW'(3);
    end else if (accept_i) begin
      mode_q <= mode_d;
      fill_q <= fill_d;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mmp_pkg::RegEnable) begin
        en_q <= cfg_data_i[mmp_pkg::EnW-1:0];
      end else begin
        cap_q <= cfg_data_i[mmp_pkg::CapW-1:0];
        if (fill_q > cap_new) fill_q <= cap_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) s0_q <= s0_d;
  end

  assign we_o    = accept_i && we;
  assign waddr_o = fill_a[AddrW-1:0];

  always_comb begin
    start_o.valid = accept_i && done && hdl != mmp_pkg::HNone;
    start_o.len   = mmp_pkg::MaxLenW'(fill_b);
    start_o.hdl   = hdl;
  end

  fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_use)
    else $error("fill count above capacity in use");

  sysex_end_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == ModeSysex && data_byte_i == mmp_pkg::SysexEnd
     && fill_q < cap_use) |=> mode_q == ModeIdle && fill_q == '0)
    else $error("sysex end byte did not close the message");

endmodule

/* rtl/mmp_emit.sv */
// message emitter: walks the store, one read per cycle unless output stalls,
// drives the output register; uses mmp_pkg, the store's registered read port
module mmp_emit #(
  parameter int unsigned Depth = mmp_pkg::DefaultDepth,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmp_pkg::start_t             start_i,
  output logic                        re_o,
  output logic [AddrW-1:0]            raddr_o,
  input  logic [7:0]                  rdata_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  msg_byte_o,
  output logic [mmp_pkg::MsgLenW-1:0] msg_length_o,
  output logic [2:0]                  handler_o,
  output logic                        last_o
);

  logic            emit_q;
  logic [CntW-1:0] ptr_q, len_q, idx1_q;
  logic [2:0]      hdl_q;
  logic            dv_q;      // read data register holds a byte
  logic            ov_q;
  logic            move1;
  logic [CntW+mmp_pkg::MsgLenW-1:0] len_ext;

  // the read data register is the first stage, the output register the second
  assign move1   = dv_q && (!ov_q || !out_stall_i);
  assign re_o    = emit_q && (!dv_q || move1);
  assign raddr_o = ptr_q[AddrW-1:0];
  assign busy_o  = emit_q || dv_q || ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      ptr_q  <= '0;
      dv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (start_i.valid) begin
        emit_q <= 1'b1;
        ptr_q  <= '0;
      end else if (re_o) begin
        ptr_q <= ptr_q + CntW'(1);
        if (ptr_q + CntW'(1) == len_q) emit_q <= 1'b0;
      end
      if (re_o)       dv_q <= 1'b1;
      else if (move1) dv_q <= 1'b0;
      if (move1)                   ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.valid) begin
      len_q <= start_i.len[CntW-1:0];
      hdl_q <= start_i.hdl;
    end
    if (re_o) idx1_q <= ptr_q;
    if (move1) begin
      msg_byte_o <= rdata_i;
      last_o     <= (idx1_q + CntW'(1) == len_q);
    end
  end

  assign len_ext      = {{mmp_pkg::MsgLenW{1'b0}}, len_q};
  assign msg_length_o = len_ext[mmp_pkg::MsgLenW-1:0];
  assign handler_o    = hdl_q;
  assign out_valid_o  = ov_q;

  read_in_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |-> ptr_q < len_q)
    else $error("store read past the end of the message");

  start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i.valid |-> !busy_o)
    else $error("new message started while emitting");

  last_after_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && last_o) |-> !emit_q)
    else $error("last byte shown with reads still pending");

endmodule

/* rtl/midi_message_parser.sv */
// midi_message_parser: takes one byte per cycle while parsing. A status byte
// opens a message, and there is no running status. Each finished message
// with an enabled handler is streamed from the message store's read port at
// one byte per cycle while the output is not stalled, and input is stalled
// until it has left. There is no clearing pass after reset. Configuration
// writes must be made only while idle; the block itself does not enforce it.
module midi_message_parser #(
  parameter int unsigned BufferDepth = mmp_pkg::DefaultDepth,
  localparam int unsigned AddrW = $clog2(BufferDepth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [mmp_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  msg_byte_o,
  output logic [mmp_pkg::MsgLenW-1:0] msg_length_o,
  output logic [2:0]                  handler_o,
  output logic                        last_o
);

  logic            accept;
  logic            busy;
  logic            we;
  logic [AddrW-1:0] waddr;
  logic            re;
  logic [AddrW-1:0] raddr;
  logic [7:0]      rdata;
  mmp_pkg::start_t start;

  // input waits until a message has fully left, so reads never meet writes
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  mmp_ctrl #(.Depth(BufferDepth)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .start_o     (start)
  );

  mmp_store #(.Depth(BufferDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mmp_emit #(.Depth(BufferDepth)) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .msg_byte_o   (msg_byte_o),
    .msg_length_o (msg_length_o),
    .handler_o    (handler_o),
    .last_o       (last_o)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench for midi_message_parser: directed table then random midi byte streams,
// every emitted byte checked against the table or a local message predictor; uses mmp_pkg
module tb;
  import mmp_pkg::*;

  localparam int unsigned Depth = DefaultDepth;
  localparam int PhaseItems = 36;
  localparam int Phases = 10;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = Depth + 8;

  // midi status nibbles and bytes
  localparam logic [3:0] NibNoteOff   = 4'h8;
  localparam logic [3:0] NibNoteOn    = 4'h9;
  localparam logic [3:0] NibPolyAt    = 4'hA;
  localparam logic [3:0] NibCc        = 4'hB;
  localparam logic [3:0] NibProg      = 4'hC;
  localparam logic [3:0] NibChanPress = 4'hD;
  localparam logic [3:0] NibBend      = 4'hE;
  localparam logic [7:0] StMtc        = 8'hF1;
  localparam logic [7:0] StSongPos    = 8'hF2;
  localparam logic [7:0] StSongSel    = 8'hF3;
  localparam logic [7:0] StUndefF4    = 8'hF4;
  localparam logic [7:0] StUndefF5    = 8'hF5;
  localparam logic [7:0] StTune       = 8'hF6;
  localparam logic [7:0] RtClock      = 8'hF8;
  localparam logic [7:0] StUndefF9    = 8'hF9;
  localparam logic [7:0] RtStart      = 8'hFA;
  localparam logic [7:0] RtCont       = 8'hFB;
  localparam logic [7:0] RtStop       = 8'hFC;
  localparam logic [7:0] StUndefFd    = 8'hFD;
  localparam logic [7:0] RtSense      = 8'hFE;
  localparam logic [7:0] RtReset      = 8'hFF;

  localparam logic [7:0] RealtimeSet [6] = '{RtClock, RtStart, RtCont, RtStop, RtSense, RtReset};
  localparam logic [7:0] UndefSet [5] = '{StUndefF4, StUndefF5, StUndefF9, StUndefFd, SysexEnd};
  localparam logic [3:0] Voice3Set [4] = '{NibNoteOff, NibNoteOn, NibPolyAt, NibBend};

  typedef enum logic [1:0] {ModeIdle, ModeMsg, ModeSysex} parse_mode_e;

  typedef struct packed {
    logic [7:0]         data;
    logic [MsgLenW-1:0] len;
    logic [2:0]         hdl;
    logic               last;
  } msg_beat_t;

  typedef enum logic [1:0] {RowByte, RowEnable, RowCap} row_kind_e;
  typedef enum logic [1:0] {ByModel, ExpNone, ExpMsg} row_chk_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] val;
    row_chk_e   chk;
    logic [2:0] hdl;
    logic [5:0] len;
  } plan_row_t;

  localparam plan_row_t Plan [38] = '{
    '{RowByte,   {NibNoteOn, 4'h0},    ByModel, HNone,    6'd0},
    '{RowByte,   8'h3C,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h7F,                ExpNone, HNone,    6'd0},  // nothing enabled after reset
    '{RowEnable, 8'h7F,                ByModel, HNone,    6'd0},
    '{RowCap,    8'h3F,                ByModel, HNone,    6'd0},  // clamps to the store depth
    '{RowByte,   RtClock,              ExpMsg,  HRt,      6'd1},
    '{RowByte,   {NibNoteOff, 4'h0},   ByModel, HNone,    6'd0},
    '{RowByte,   8'h00,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h7F,                ExpMsg,  HVoice,   6'd3},
    '{RowByte,   {NibProg, 4'hF},      ByModel, HNone,    6'd0},
    '{RowByte,   RtSense,              ExpMsg,  HRt,      6'd1},  // realtime cuts the message
    '{RowByte,   {NibCc, 4'h5},        ByModel, HNone,    6'd0},
    '{RowByte,   8'h07,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h64,                ExpMsg,  HCc,      6'd3},
    '{RowByte,   StMtc,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h12,                ExpMsg,  HMtc,     6'd2},
    '{RowByte,   StSongPos,            ByModel, HNone,    6'd0},
    '{RowByte,   8'h01,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h02,                ExpMsg,  HCommon,  6'd3},
    '{RowByte,   StTune,               ExpMsg,  HCommon,  6'd1},
    '{RowByte,   SysexStart,           ByModel, HNone,    6'd0},
    '{RowByte,   8'h7D,                ByModel, HNone,    6'd0},
    '{RowByte,   SysexEnd,             ExpMsg,  HSysex,   6'd3},
    '{RowByte,   SysexStart,           ByModel, HNone,    6'd0},
    '{RowByte,   {NibNoteOn, 4'h1},    ExpNone, HNone,    6'd0},  // status inside sysex drops it
    '{RowByte,   8'h45,                ExpNone, HNone,    6'd0},  // data while idle
    '{RowCap,    8'h02,                ByModel, HNone,    6'd0},
    '{RowByte,   StUndefF4,            ByModel, HNone,    6'd0},
    '{RowByte,   8'h01,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h02,                ExpNone, HNone,    6'd0},  // overflow
    '{RowCap,    8'h00,                ByModel, HNone,    6'd0},
    '{RowByte,   RtReset,              ExpNone, HNone,    6'd0},
    '{RowEnable, 8'h40,                ByModel, HNone,    6'd0},
    '{RowCap,    8'h20,                ByModel, HNone,    6'd0},
    '{RowByte,   {NibBend, 4'h3},      ByModel, HNone,    6'd0},
    '{RowByte,   8'h00,                ByModel, HNone,    6'd0},
    '{RowByte,   8'h7F,                ExpMsg,  HDefault, 6'd3},
    '{RowByte,   RtReset,              ExpMsg,  HDefault, 6'd1}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = 8'h00;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = RegEnable;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           msg_byte_o;
  logic [MsgLenW-1:0]   msg_length_o;
  logic [2:0]           handler_o;
  logic                 last_o;

  midi_message_parser #(.BufferDepth(Depth)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .msg_byte_o, .msg_length_o, .handler_o, .last_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  parse_mode_e mode = ModeIdle;
  int          fill = 0;
  logic [7:0]  store [Depth];
  logic [6:0]  en_reg = 7'h00;
  logic [5:0]  cap_reg = 6'd3;

  msg_beat_t   fresh_beats [$];
  msg_beat_t   pending_beats [$];
  logic [7:0]  history [$];
  int          mismatches = 0;
  int          phase_items = 0;
  int          burst_left = 0;
  logic        steady = 1'b0;
  logic        hold_req = 1'b0;

  function automatic int cap_use();
    return (cap_reg < Depth) ? int'(cap_reg) : int'(Depth);
  endfunction

  function automatic logic [2:0] first_enabled(logic [2:0] a, logic [2:0] b);
    if (a != HNone && en_reg[a]) return a;
    if (b != HNone && en_reg[b]) return b;
    if (en_reg[HDefault]) return HDefault;
    return HNone;
  endfunction

  function automatic void close_message(logic [2:0] h);
    msg_beat_t beat;
    if (h != HNone) begin
      for (int k = 0; k < fill; k++) begin
        beat.data = store[k];
        beat.len  = MsgLenW'(fill);
        beat.hdl  = h;
        beat.last = (k + 1 == fill);
        fresh_beats.push_back(beat);
      end
    end
    mode = ModeIdle;
    fill = 0;
  endfunction

  // advance the parser by one byte, leaving the bytes it sends in fresh_beats
  function automatic void parse_byte(logic [7:0] b);
    logic [7:0] s0;
    logic [3:0] hi;
    fresh_beats.delete();
    if ((b & StatusMask) != 0) begin
      if (mode == ModeSysex) begin
        if (b != SysexEnd) begin
          mode = ModeIdle;
          fill = 0;
        end
      end else if (b == SysexStart) begin
        mode = ModeSysex;
        fill = 0;
      end else begin
        mode = ModeMsg;
        fill = 0;
      end
    end
    if (mode != ModeIdle) begin
      if (fill < cap_use()) begin
        store[fill] = b;
        fill++;
      end else begin
        mode = ModeIdle;
        fill = 0;
      end
    end
    if (mode == ModeMsg && fill > 0) begin
      s0 = store[0];
      hi = s0[7:4];
      if (fill == 1) begin
        if (s0 inside {RtClock, RtStart, RtCont, RtStop, RtSense, RtReset}) begin
          close_message(first_enabled(HRt, HNone));
        end else if (s0 == StTune) begin
          close_message(first_enabled(HCommon, HNone));
        end
      end else if (fill == 2) begin
        if (hi == NibProg || hi == NibChanPress) begin
          close_message(first_enabled(HVoice, HNone));
        end else if (s0 == StMtc) begin
          close_message(first_enabled(HMtc, HCommon));
        end else if (s0 == StSongSel) begin
          close_message(first_enabled(HCommon, HNone));
        end
      end else if (fill == 3) begin
        if (hi == NibCc) begin
          close_message(first_enabled(HCc, HVoice));
        end else if (hi inside {NibNoteOff, NibNoteOn, NibPolyAt, NibBend}) begin
          close_message(first_enabled(HVoice, HNone));
        end else if (s0 == StSongPos) begin
          close_message(first_enabled(HCommon, HNone));
        end
      end
    end
    if (mode == ModeSysex && fill > 0 && store[fill-1] == SysexEnd) begin
      close_message(first_enabled(HSysex, HNone));
    end
  endfunction

  function automatic logic [7:0] data7();
    return {1'b0, 7'($urandom_range(0, 127))};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100) begin
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  // hand one item to the block; sender idles between bursts unless steady
  task automatic send_item(input logic [7:0] b);
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    parse_byte(b);
    history.push_back(b);
  endtask

  task automatic offer(input logic [7:0] b);
    send_item(b);
    foreach (fresh_beats[k]) pending_beats.push_back(fresh_beats[k]);
    phase_items++;
  endtask

  // wait until every expected byte is out and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegEnable) begin
      en_reg = val[6:0];
    end else begin
      cap_reg = val[5:0];
      if (fill > cap_use()) fill = cap_use();
    end
  endtask

  task automatic offer_random_message();
    int         kind_pick;
    int         n;
    logic [3:0] chan;
    kind_pick = $urandom_range(0, 99);
    chan = 4'($urandom_range(0, 15));
    if (kind_pick < 10) begin
      offer(RealtimeSet[$urandom_range(0, 5)]);
    end else if (kind_pick < 28) begin
      offer({Voice3Set[$urandom_range(0, 3)], chan});
      offer(data7());
      if ($urandom_range(0, 9) == 0) offer(RealtimeSet[$urandom_range(0, 5)]);
      offer(data7());
    end else if (kind_pick < 38) begin
      offer({NibCc, chan});
      offer(data7());
      offer(data7());
    end else if (kind_pick < 48) begin
      offer({($urandom_range(0, 1) != 0) ? NibProg : NibChanPress, chan});
      offer(data7());
    end else if (kind_pick < 58) begin
      case ($urandom_range(0, 3))
        0: begin
          offer(StMtc);
          offer(data7());
        end
        1: begin
          offer(StSongPos);
          offer(data7());
          offer(data7());
        end
        2: begin
          offer(StSongSel);
          offer(data7());
        end
        default: offer(StTune);
      endcase
    end else if (kind_pick < 73) begin
      // mostly short sysex, now and then a long one
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 31) : $urandom_range(0, 6);
      offer(SysexStart);
      repeat (n) offer(data7());
      offer(SysexEnd);
    end else begin
      case ($urandom_range(0, 4))
        0: offer(8'($urandom_range(0, 255)));
        1: begin
          offer({Voice3Set[$urandom_range(0, 3)], chan});
          if ($urandom_range(0, 1) != 0) offer(data7());
        end
        2: begin
          offer(UndefSet[$urandom_range(0, 4)]);
          repeat ($urandom_range(0, 4)) offer(data7());
        end
        3: begin
          offer(SysexStart);
          repeat ($urandom_range(0, 3)) offer(data7());
          offer({1'b1, 7'($urandom_range(0, 127))});
        end
        default: repeat ($urandom_range(1, 3)) offer(data7());
      endcase
    end
  endtask

  // receiver: stall styles in spans, plus one long hold-off on request
  initial begin
    int style;
    int span;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(10, 150);
        for (int i = 0; i < span && !hold_req; i++) begin
          case (style)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 1) != 0);
            2: out_stall_i <= (i % 4 == 3);
            default: out_stall_i <= ($urandom_range(0, 9) < 8);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    msg_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("item with nothing expected", msg_byte_o, 0);
      end else begin
        want = pending_beats.pop_front();
        if (msg_byte_o !== want.data) report_mismatch("msg_byte", msg_byte_o, want.data);
        if (msg_length_o !== want.len) report_mismatch("msg_length", msg_length_o, want.len);
        if (handler_o !== want.hdl) report_mismatch("handler", handler_o, want.hdl);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    msg_beat_t       beat;
    int              n;
    logic [6:0]      phase_en;
    logic [5:0]      phase_cap;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Plan[i]) begin
      case (Plan[i].kind)
        RowEnable: begin
          settle();
          write_reg(RegEnable, Plan[i].val[6:0]);
        end
        RowCap: begin
          settle();
          write_reg(RegCapacity, {1'b0, Plan[i].val[5:0]});
        end
        default: begin
          send_item(Plan[i].val);
          case (Plan[i].chk)
            ByModel: foreach (fresh_beats[k]) pending_beats.push_back(fresh_beats[k]);
            ExpMsg: begin
              // message made of the last len bytes sent
              n = Plan[i].len;
              for (int k = 0; k < n; k++) begin
                beat.data = history[history.size() - n + k];
                beat.len  = MsgLenW'(n);
                beat.hdl  = Plan[i].hdl;
                beat.last = (k == n - 1);
                pending_beats.push_back(beat);
              end
            end
            default: ;
          endcase
        end
      endcase
    end

    for (int p = 0; p < Phases; p++) begin
      settle();
      case (p)
        0: begin
          phase_en  = 7'h7F;
          phase_cap = 6'd32;
        end
        1: begin
          phase_en  = 7'h00;
          phase_cap = 6'd32;
        end
        2: begin
          phase_en  = 7'h40;
          phase_cap = 6'd33;
        end
        3: begin
          phase_en  = 7'($urandom_range(0, 127));
          phase_cap = 6'd0;
        end
        4: begin
          phase_en  = 7'($urandom_range(0, 127));
          phase_cap = 6'($urandom_range(1, 2));
        end
        5: begin
          phase_en  = 7'($urandom_range(0, 127));
          phase_cap = 6'($urandom_range(33, 63));
        end
        default: begin
          phase_en  = 7'($urandom_range(0, 127));
          phase_cap = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'($urandom_range(3, 31));
        end
      endcase
      write_reg(RegEnable, phase_en);
      write_reg(RegCapacity, {1'b0, phase_cap});
      steady = ($urandom_range(0, 9) < 3);
      if (p == 0) begin
        // long receiver hold-off while items keep coming
        steady   = 1'b1;
        hold_req = 1'b1;
      end
      phase_items = 0;
      while (phase_items < PhaseItems) offer_random_message();
    end

    settle();
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* midi_message_parser.f */
rtl/mmp_pkg.sv
rtl/mmp_store.sv
rtl/mmp_ctrl.sv
rtl/mmp_emit.sv
rtl/midi_message_parser.sv
verif/tb.sv
